/* hdl/rd32_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd32_pkg
// shared types and constants of the 32-bit range decoder
// ----------------------------------------------------------------------------
package rd32_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_START  = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_DECODE = 2'd3
  } cmd_t;

  localparam logic [31:0] TOP_MASK  = 32'hFF00_0000;
  localparam logic [31:0] GAP_WIDE  = 32'h0001_0000;
  localparam logic [31:0] GAP_MID   = 32'h0000_1000;
  localparam logic [31:0] MID_DELTA = 32'h0000_00FF;
  localparam logic [31:0] LOW_INIT  = 32'h0000_0001;
  localparam logic [31:0] HIGH_INIT = 32'hFFFF_FFFF;
  localparam int          RENORM_ROUNDS = 64;

  // command entry between front and back
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  byte_in;
    logic [15:0] total;
    logic [15:0] lo_cum;
    logic [15:0] hi_cum;
  } op_t;

  // queue status: full flag and level
  typedef struct packed {
    logic       full;
    logic [4:0] level;
  } qstat_t;

endpackage

/* hdl/range_decoder_32bit_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_decoder_32bit_unit
// 32-bit byte-renormalizing range decoder with an input byte queue
// ----------------------------------------------------------------------------
// Each item gives exactly one result, in order. Pushes travel through the same
// command queue as the other commands and write the byte queue only when the
// back part reaches them, so every result shows the byte queue as it stands
// right after its own item. A push goes straight to its result, a start loads
// four code bytes, a query runs up to two divisions on the one-bit-per-cycle
// divider, and a decode runs its renormalization rounds (at most 64). After
// each result the back part returns to idle before taking the next item. The
// front holds up to two items ahead while the back part works; a waiting result
// holds the back part only, and the input stalls once both entries are taken.
module range_decoder_32bit_unit #(
  parameter int QUEUE_DEPTH = rd32_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_byte_in,
  input  logic [15:0] in_total,
  input  logic [15:0] in_lo_cum,
  input  logic [15:0] in_hi_cum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_symbol_count,
  output logic        out_query_done,
  output logic        out_arith_error,
  output logic        out_queue_full,
  output logic [4:0]  out_queue_level
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rd32_pkg::op_t op_data;
  logic          op_valid, op_take, op_push_only, byte_pop;
  logic [7:0]    byte_data;
  logic [CW-1:0] byte_count;

  rd32_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_byte_in, .in_total,
    .in_lo_cum, .in_hi_cum, .op_valid, .op_data, .op_push_only, .op_take,
    .byte_pop, .byte_data, .byte_count
  );

  rd32_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk, .rst_n, .op_valid, .op_data, .op_push_only, .op_take, .byte_pop,
    .byte_data, .byte_count, .out_valid, .out_stall, .out_symbol_count,
    .out_query_done, .out_arith_error, .out_queue_full, .out_queue_level
  );

endmodule

/* hdl/rd32_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd32_front
// accepts items into a short command queue and holds the byte queue, which
// the back part fills and drains in item order
// ----------------------------------------------------------------------------
module rd32_front #(
  parameter int QUEUE_DEPTH = rd32_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_byte_in,
  input  logic [15:0]       in_total,
  input  logic [15:0]       in_lo_cum,
  input  logic [15:0]       in_hi_cum,
  // command queue toward the back part
  output logic              op_valid,
  output rd32_pkg::op_t     op_data,
  output logic              op_push_only,
  input  logic              op_take,
  // byte reads from the back part
  input  logic              byte_pop,
  output logic [7:0]        byte_data,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] byte_count
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [PW-1:0] rd_ptr_r, wr_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r;
  logic [7:0]    head_r;

  // two-entry command queue; a push becomes an entry too so results stay in order
  rd32_pkg::op_t cq_data_r [2];
  logic [1:0]    cq_push_r;
  logic          cq_head_r, cq_tail_r;
  logic [1:0]    cq_cnt_r;

  logic acc, push_ok;

  assign in_stall = (cq_cnt_r == 2'd2);
  assign acc      = in_valid && !in_stall;

  assign op_valid     = (cq_cnt_r != 2'd0);
  assign op_data      = cq_data_r[cq_head_r];
  assign op_push_only = cq_push_r[cq_head_r];

  // a pushed byte lands in the byte queue when the back part takes its item, unless the queue is full
  assign push_ok    = op_take && op_push_only && (cnt_r < CW'(QUEUE_DEPTH));
  assign rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign byte_data  = head_r;
  assign byte_count = cnt_r;

  // byte storage
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr_r] <= op_data.byte_in;
    end
  end

  // registered head byte, refilled on each pop or on a push into an empty queue
  always_ff @(posedge clk) begin
    if (push_ok && cnt_r == '0) begin
      head_r <= op_data.byte_in;
    end else if (byte_pop) begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  // pointers and counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      cnt_r     <= '0;
      cq_head_r <= 1'b0;
      cq_tail_r <= 1'b0;
      cq_cnt_r  <= '0;
      cq_push_r <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (byte_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_r + CW'(push_ok) - CW'(byte_pop);
      if (acc) begin
        cq_tail_r            <= ~cq_tail_r;
        cq_push_r[cq_tail_r] <= (rd32_pkg::cmd_t'(in_cmd) == rd32_pkg::CMD_PUSH);
      end
      if (op_take) begin
        cq_head_r <= ~cq_head_r;
      end
      cq_cnt_r <= cq_cnt_r + 2'(acc) - 2'(op_take);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cq_data_r[cq_tail_r] <= '{cmd: rd32_pkg::cmd_t'(in_cmd), byte_in: in_byte_in,
                               total: in_total, lo_cum: in_lo_cum, hi_cum: in_hi_cum};
    end
  end

endmodule

/* hdl/rd32_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd32_div
// restoring 32 by 32 unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rd32_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] q_r, d_r;
  logic [32:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted  = {rem_r[31:0], q_r[31]};
  assign trial    = shifted - {1'b0, d_r};
  assign quotient = q_r;

  // iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial;
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= shifted;
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

endmodule

/* hdl/rd32_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd32_back
// carries out start, query and decode on the interval state and renormalizes
// ----------------------------------------------------------------------------
module rd32_back #(
  parameter int QUEUE_DEPTH = rd32_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  rd32_pkg::op_t      op_data,
  input  logic               op_push_only,
  output logic               op_take,
  output logic               byte_pop,
  input  logic [7:0]         byte_data,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] byte_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_symbol_count,
  output logic               out_query_done,
  output logic               out_arith_error,
  output logic               out_queue_full,
  output logic [4:0]         out_queue_level
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DIV1, S_WAIT1, S_DIV2, S_WAIT2, S_MUL, S_DEC, S_RENORM, S_OUT
  } state_t;

  state_t        state_r;
  logic [31:0]   lo_r, hi_r, code_r, rq_r;
  logic [31:0]   prod_lo_r, prod_hi_r;
  logic [15:0]   total_r, lowc_r, highc_r, sym_r;
  logic          err_r;
  logic [2:0]    nb_r;
  logic [6:0]    round_r;
  logic          div_start;
  logic [31:0]   div_a, div_b, div_q;
  logic          div_done;
  logic [31:0]   gap, mid;
  logic          same_top, have_byte;
  logic [7:0]    nb_byte;

  assign gap       = hi_r - lo_r;
  assign mid       = {1'b0, hi_r[31:1]} + {1'b0, lo_r[31:1]};
  assign same_top  = ((hi_r & rd32_pkg::TOP_MASK) == (lo_r & rd32_pkg::TOP_MASK));
  assign have_byte = (byte_count != '0);
  assign nb_byte   = have_byte ? byte_data : 8'd0;
  assign op_take   = (state_r == S_IDLE) && op_valid;

  // divider operands depend on which division runs
  always_comb begin
    div_start = 1'b0;
    div_a     = hi_r - lo_r + 32'd1;
    div_b     = {16'd0, total_r};
    if (state_r == S_DIV1) begin
      div_start = 1'b1;
    end else if (state_r == S_DIV2) begin
      div_start = 1'b1;
      div_a     = code_r - lo_r;
      div_b     = rq_r;
    end
  end

  // byte read happens in start loading and in shift rounds of renormalization
  always_comb begin
    byte_pop = 1'b0;
    if (have_byte) begin
      if (state_r == S_START && nb_r != 3'd4) begin
        byte_pop = 1'b1;
      end else if (state_r == S_RENORM && round_r != 7'(rd32_pkg::RENORM_ROUNDS) &&
                   same_top) begin
        byte_pop = 1'b1;
      end
    end
  end

  rd32_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  // control sequencer with state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      lo_r      <= rd32_pkg::LOW_INIT;
      hi_r      <= rd32_pkg::HIGH_INIT;
      code_r    <= '0;
      rq_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (op_valid) begin
            total_r <= op_data.total;
            lowc_r  <= op_data.lo_cum;
            highc_r <= op_data.hi_cum;
            sym_r   <= '0;
            err_r   <= 1'b0;
            if (op_push_only) begin
              state_r <= S_OUT;
            end else begin
              unique case (op_data.cmd)
                rd32_pkg::CMD_START: begin
                  rq_r    <= '0;
                  lo_r    <= rd32_pkg::LOW_INIT;
                  hi_r    <= rd32_pkg::HIGH_INIT;
                  code_r  <= '0;
                  nb_r    <= '0;
                  state_r <= S_START;
                end
                rd32_pkg::CMD_QUERY: begin
                  if (op_data.total == '0) begin
                    err_r   <= 1'b1;
                    state_r <= S_OUT;
                  end else begin
                    state_r <= S_DIV1;
                  end
                end
                default: state_r <= S_MUL;
              endcase
            end
          end
        end
        S_START: begin
          if (nb_r == 3'd4) begin
            state_r <= S_OUT;
          end else begin
            code_r <= {code_r[23:0], nb_byte};
            nb_r   <= nb_r + 1'b1;
          end
        end
        S_DIV1:  state_r <= S_WAIT1;
        S_WAIT1: begin
          if (div_done) begin
            rq_r <= div_q;
            if (div_q == '0) begin
              err_r   <= 1'b1;
              state_r <= S_OUT;
            end else begin
              state_r <= S_DIV2;
            end
          end
        end
        S_DIV2:  state_r <= S_WAIT2;
        S_WAIT2: begin
          if (div_done) begin
            sym_r   <= (div_q < {16'd0, total_r}) ? div_q[15:0] : total_r - 16'd1;
            state_r <= S_OUT;
          end
        end
        S_MUL: begin
          prod_lo_r <= rq_r * {16'd0, lowc_r};
          prod_hi_r <= rq_r * {16'd0, highc_r};
          state_r   <= S_DEC;
        end
        S_DEC: begin
          hi_r    <= lo_r + prod_hi_r - 32'd1;
          lo_r    <= lo_r + prod_lo_r;
          rq_r    <= '0;
          round_r <= '0;
          state_r <= S_RENORM;
        end
        S_RENORM: begin
          if (round_r == 7'(rd32_pkg::RENORM_ROUNDS)) begin
            state_r <= S_OUT;
          end else if (!same_top) begin
            if (gap >= rd32_pkg::GAP_WIDE) begin
              state_r <= S_OUT;
            end else if (gap > rd32_pkg::GAP_MID) begin
              hi_r <= mid + rd32_pkg::MID_DELTA;
              lo_r <= mid - rd32_pkg::MID_DELTA;
            end else begin
              hi_r <= mid;
              lo_r <= mid;
            end
            round_r <= round_r + 1'b1;
          end else begin
            code_r  <= {code_r[23:0], nb_byte};
            hi_r    <= {hi_r[23:0], 8'hFF};
            lo_r    <= ({lo_r[23:0], 8'h00} == '0) ? rd32_pkg::LOW_INIT
                                                   : {lo_r[23:0], 8'h00};
            round_r <= round_r + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result fields; queue level sampled when the result is raised
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && !out_valid) begin
      out_symbol_count <= sym_r;
      out_query_done   <= (rq_r != '0);
      out_arith_error  <= err_r;
      out_queue_full   <= (byte_count >= CW'(QUEUE_DEPTH));
      out_queue_level  <= 5'(byte_count);
    end
  end

endmodule

/* hdl/rd32_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rd32_checker
// port-level checks of the range decoder
// ----------------------------------------------------------------------------
module rd32_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_symbol_count,
  input logic        out_arith_error,
  input logic        out_queue_full,
  input logic [4:0]  out_queue_level
);

  // a flagged query reports no count
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_arith_error |-> out_symbol_count == 16'd0)
    else $error("error result with nonzero count");

  // full flag agrees with level
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_full |-> out_queue_level == 5'd16)
    else $error("full flag without full level");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol_count))
    else $error("stalled result changed");

  // stalled input item stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input item withdrawn");

  // no result right out of reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind range_decoder_32bit_unit rd32_checker u_rd32_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_symbol_count,
  .out_arith_error, .out_queue_full, .out_queue_level
);

/* tb/sv/tb_range_decoder_32bit_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_decoder_32bit_unit
// self-checking bench for the range decoder: directed and random command
// streams, a local decoder model predicting every result, random gaps on both
// channels and an in-order compare of each returned item
// ----------------------------------------------------------------------------
module tb_range_decoder_32bit_unit;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  byte_in;
    logic [15:0] total;
    logic [15:0] lo_cum;
    logic [15:0] hi_cum;
  } item_t;

  typedef struct packed {
    logic [15:0] symbol_count;
    logic        query_done;
    logic        arith_error;
    logic        queue_full;
    logic [4:0]  queue_level;
  } result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [7:0]  in_byte_in = '0;
  logic [15:0] in_total = '0;
  logic [15:0] in_lo_cum = '0;
  logic [15:0] in_hi_cum = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_symbol_count;
  logic        out_query_done;
  logic        out_arith_error;
  logic        out_queue_full;
  logic [4:0]  out_queue_level;

  range_decoder_32bit_unit #(.QUEUE_DEPTH(DEPTH)) dut (.*);

  // decoder state mirrored by the bench
  logic [31:0] m_low, m_high, m_code, m_quot;
  logic [7:0]  m_bytes [DEPTH];
  int          m_rd, m_wr, m_cnt;

  item_t   pending_items [$];
  result_t expected_results [$];
  int      errors = 0;
  bit      drain_hold = 0;
  int      quiet_cycles = 0;
  int      in_gap = 0;
  int      out_gap = 0;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [7:0] next_byte();
    logic [7:0] b;
    if (m_cnt == 0) return 8'h00;
    b = m_bytes[m_rd];
    m_rd = (m_rd + 1) % DEPTH;
    m_cnt--;
    return b;
  endfunction

  function automatic void renorm_interval();
    logic [31:0] hi, lo, gap, mid;
    for (int r = 0; r < rd32_pkg::RENORM_ROUNDS; r++) begin
      hi = m_high;
      lo = m_low;
      if ((hi & rd32_pkg::TOP_MASK) != (lo & rd32_pkg::TOP_MASK)) begin
        gap = hi - lo;
        if (gap >= rd32_pkg::GAP_WIDE) break;
        mid = (hi >> 1) + (lo >> 1);
        if (gap > rd32_pkg::GAP_MID) begin
          m_high = mid + rd32_pkg::MID_DELTA;
          m_low  = mid - rd32_pkg::MID_DELTA;
        end else begin
          m_high = mid;
          m_low  = mid;
        end
      end else begin
        m_code = (m_code << 8) | {24'h0, next_byte()};
        m_high = (hi << 8) | rd32_pkg::MID_DELTA;
        m_low  = lo << 8;
        if (m_low == 32'h0) m_low = rd32_pkg::LOW_INIT;
      end
    end
  endfunction

  // advance the local decoder by one item and return its result
  function automatic result_t decode_step(item_t it);
    result_t     res;
    logic [31:0] t, base;
    res = '0;
    unique case (rd32_pkg::cmd_t'(it.cmd))
      rd32_pkg::CMD_PUSH: begin
        if (m_cnt < DEPTH) begin
          m_bytes[m_wr] = it.byte_in;
          m_wr = (m_wr + 1) % DEPTH;
          m_cnt++;
        end
      end
      rd32_pkg::CMD_START: begin
        m_quot = '0;
        m_low  = rd32_pkg::LOW_INIT;
        m_high = rd32_pkg::HIGH_INIT;
        m_code = '0;
        for (int i = 0; i < 4; i++) m_code = (m_code << 8) | {24'h0, next_byte()};
      end
      rd32_pkg::CMD_QUERY: begin
        if (it.total == 16'h0) begin
          res.arith_error = 1'b1;
        end else begin
          m_quot = (m_high - m_low + 32'd1) / {16'h0, it.total};
          if (m_quot == 32'h0) begin
            res.arith_error = 1'b1;
          end else begin
            t = (m_code - m_low) / m_quot;
            res.symbol_count = (t < {16'h0, it.total}) ? t[15:0] : it.total - 16'd1;
          end
        end
      end
      default: begin
        base   = m_low;
        m_high = base + m_quot * {16'h0, it.hi_cum} - 32'd1;
        m_low  = base + m_quot * {16'h0, it.lo_cum};
        m_quot = '0;
        renorm_interval();
      end
    endcase
    res.query_done  = (m_quot != 32'h0);
    res.queue_full  = (m_cnt >= DEPTH);
    res.queue_level = m_cnt[4:0];
    return res;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic item_t mk(logic [1:0] c, logic [7:0] b, logic [15:0] t,
                               logic [15:0] lc, logic [15:0] hc);
    item_t it;
    it.cmd = c; it.byte_in = b; it.total = t; it.lo_cum = lc; it.hi_cum = hc;
    return it;
  endfunction

  function automatic item_t rand_item(logic [1:0] c);
    logic [15:0] tot, lc, hc;
    tot = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
    lc  = 16'($urandom_range(0, tot));
    hc  = 16'($urandom_range(lc, tot));
    return mk(c, 8'($urandom), tot, lc, hc);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_gap > 0 || drain_hold || pending_items.size() == 0) begin
        if (in_gap > 0) in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else begin
        item_t it;
        it = pending_items.pop_front();
        expected_results.push_back(decode_step(it));
        in_valid   <= 1'b1;
        in_cmd     <= it.cmd;
        in_byte_in <= it.byte_in;
        in_total   <= it.total;
        in_lo_cum  <= it.lo_cum;
        in_hi_cum  <= it.hi_cum;
        in_gap     <= pick_gap();
      end
    end
  end

  // result stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      out_gap   <= pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_t got, exp_r;
      got = {out_symbol_count, out_query_done, out_arith_error, out_queue_full,
             out_queue_level};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item, actual %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.symbol_count !== exp_r.symbol_count)
          $display("%0t: symbol_count expected %h actual %h", $time,
                   exp_r.symbol_count, got.symbol_count);
        if (got.query_done !== exp_r.query_done)
          $display("%0t: query_done expected %b actual %b", $time,
                   exp_r.query_done, got.query_done);
        if (got.arith_error !== exp_r.arith_error)
          $display("%0t: arith_error expected %b actual %b", $time,
                   exp_r.arith_error, got.arith_error);
        if (got.queue_full !== exp_r.queue_full)
          $display("%0t: queue_full expected %b actual %b", $time,
                   exp_r.queue_full, got.queue_full);
        if (got.queue_level !== exp_r.queue_level)
          $display("%0t: queue_level expected %h actual %h", $time,
                   exp_r.queue_level, got.queue_level);
        if (got !== exp_r) errors++;
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** range_decoder_32bit_unit: FAILED **");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int sel, nbytes;
    m_low = rd32_pkg::LOW_INIT; m_high = rd32_pkg::HIGH_INIT; m_code = '0; m_quot = '0;
    m_rd = 0; m_wr = 0; m_cnt = 0;
    foreach (m_bytes[i]) m_bytes[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: start and decode on empty queue, zero total, fill past full
    pending_items.push_back(mk(rd32_pkg::CMD_START, 8'h00, 16'h0, 16'h0, 16'h0));
    pending_items.push_back(mk(rd32_pkg::CMD_QUERY, 8'h00, 16'h0000, 16'h0, 16'h0));
    pending_items.push_back(mk(rd32_pkg::CMD_DECODE, 8'h00, 16'h0, 16'hFFFF, 16'hFFFF));
    for (int i = 0; i < 17; i++)
      pending_items.push_back(mk(rd32_pkg::CMD_PUSH, (i % 2) ? 8'hFF : 8'h00, 16'hFFFF,
                                 16'h0, 16'h0));
    pending_items.push_back(mk(rd32_pkg::CMD_START, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_items.push_back(mk(rd32_pkg::CMD_QUERY, 8'h00, 16'hFFFF, 16'h0, 16'h0));
    pending_items.push_back(mk(rd32_pkg::CMD_DECODE, 8'h00, 16'h0, 16'h0, 16'hFFFF));
    pending_items.push_back(mk(rd32_pkg::CMD_QUERY, 8'h00, 16'h0001, 16'h0, 16'h0));
    pending_items.push_back(mk(rd32_pkg::CMD_DECODE, 8'h00, 16'h0, 16'h0, 16'h0001));

    // let everything drain once before random traffic
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    drain_hold = 1;
    repeat (5) @(posedge clk);
    drain_hold = 0;

    // random: mostly pushes, sometimes a start, then query/decode pairs; some noise
    while (pending_items.size() < 1200) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        nbytes = $urandom_range(0, 8);
        for (int i = 0; i < nbytes; i++)
          pending_items.push_back(rand_item(rd32_pkg::CMD_PUSH));
        if ($urandom_range(0, 3) == 0)
          pending_items.push_back(rand_item(rd32_pkg::CMD_START));
        pending_items.push_back(rand_item(rd32_pkg::CMD_QUERY));
        pending_items.push_back(rand_item(rd32_pkg::CMD_DECODE));
      end else begin
        pending_items.push_back(rand_item(2'($urandom_range(0, 3))));
        pending_items.push_back(mk(2'($urandom), 8'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom)));
      end
    end

    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** range_decoder_32bit_unit: PASSED **");
    end else begin
      $display("** range_decoder_32bit_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* range_decoder_32bit_unit.f */
hdl/rd32_pkg.sv
hdl/rd32_front.sv
hdl/rd32_div.sv
hdl/rd32_back.sv
hdl/range_decoder_32bit_unit.sv
hdl/rd32_checker.sv
tb/sv/tb_range_decoder_32bit_unit.sv
